// ===== hw/rtl/fcfs_schedule_calculator_defines.svh =====
// Assertion macros for fcfs_schedule_calculator.sv.
`ifndef FCFS_SCHEDULE_CALCULATOR_DEFINES_SVH
`define FCFS_SCHEDULE_CALCULATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FCFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FCFS_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define FCFS_ASSERT(lbl, clk, rstn, prop, msg)
`define FCFS_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/fcfs_pkg.sv =====
`timescale 1ns / 1ps
package fcfs_pkg;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned TIME_W = 22;
  localparam int unsigned TOT_W  = 27;
  localparam int unsigned AVG_W  = 30;
  localparam int unsigned PID_W  = 6;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned DIVD_W = TOT_W + FRAC_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_DIV
  } fsm_state_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/fcfs_cell.sv =====
`timescale 1ns / 1ps
module fcfs_cell #(
  parameter int TW = 16,
  parameter int IW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcfs_pkg::cell_ctrl_t ctrl,
  input  logic [TW-1:0]        new_arr,
  input  logic [TW-1:0]        new_bur,
  input  logic [IW-1:0]        new_idx,
  input  logic                 lft_ins,
  input  logic                 lft_val,
  input  logic [TW-1:0]        lft_arr,
  input  logic [TW-1:0]        lft_bur,
  input  logic [IW-1:0]        lft_idx,
  input  logic                 rgt_val,
  input  logic [TW-1:0]        rgt_arr,
  input  logic [TW-1:0]        rgt_bur,
  input  logic [IW-1:0]        rgt_idx,
  output logic                 val,
  output logic [TW-1:0]        arr,
  output logic [TW-1:0]        bur,
  output logic [IW-1:0]        idx,
  output logic                 ins
);
  import fcfs_pkg::*;

  logic          val_r;
  logic [TW-1:0] arr_r;
  logic [TW-1:0] bur_r;
  logic [IW-1:0] idx_r;

  assign ins = !val_r || (arr_r > new_arr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else if (ctrl.ins && ins) begin
      val_r <= lft_ins ? lft_val : 1'b1;
    end else if (ctrl.pop) begin
      val_r <= rgt_val;
    end
  end

  // shift right past the new beat, or take it; shift left on pop
  always_ff @(posedge clk) begin
    if (ctrl.ins && ins) begin
      if (lft_ins) begin
        arr_r <= lft_arr;
        bur_r <= lft_bur;
        idx_r <= lft_idx;
      end else begin
        arr_r <= new_arr;
        bur_r <= new_bur;
        idx_r <= new_idx;
      end
    end else if (ctrl.pop) begin
      arr_r <= rgt_arr;
      bur_r <= rgt_bur;
      idx_r <= rgt_idx;
    end
  end

  assign val = val_r;
  assign arr = arr_r;
  assign bur = bur_r;
  assign idx = idx_r;

endmodule

// ===== hw/rtl/fcfs_div.sv =====
`timescale 1ns / 1ps
module fcfs_div #(
  parameter int DW = 35,
  parameter int VW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import fcfs_pkg::*;

  localparam int SW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] d_r;
  logic [VW:0]   sh;
  logic          ge;

  assign sh = {rem_r, q_r[DW-1]};
  assign ge = sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(DW);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle while busy, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? VW'(sh - {1'b0, d_r}) : sh[VW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hw/rtl/fcfs_schedule_calculator.sv =====
`timescale 1ns / 1ps
// Load: one beat per cycle into a sorting row of MAX_PROCS cells (insert in arrival order).
// After the beat that ends a set (last, or MAX_PROCS beats), input stalls: n pops, one per
// cycle while out_ready holds, show the first n - 1 results, then bit-serial division of both
// totals, then the final result with both averages; in_ready returns with the final beat.
// Reset (rst_n low, synchronous) empties the cells, clears counters, totals and out_valid.
`include "fcfs_schedule_calculator_defines.svh"
module fcfs_schedule_calculator #(
  parameter int MAX_PROCS = 32,
  parameter int TIME_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fcfs_pkg::IN_W-1:0]     in_arrival,
  input  logic [fcfs_pkg::IN_W-1:0]     in_burst,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fcfs_pkg::PID_W-1:0]    out_proc_id,
  output logic [fcfs_pkg::IN_W-1:0]     out_arrival_out,
  output logic [fcfs_pkg::IN_W-1:0]     out_burst_out,
  output logic [fcfs_pkg::TIME_W-1:0]   out_completion,
  output logic [fcfs_pkg::TIME_W-1:0]   out_turnaround,
  output logic [fcfs_pkg::TIME_W-1:0]   out_waiting,
  output logic [fcfs_pkg::AVG_W-1:0]    out_avg_turnaround_q8,
  output logic [fcfs_pkg::AVG_W-1:0]    out_avg_waiting_q8,
  output logic                          out_done_res
);
  import fcfs_pkg::*;

  localparam int TW = (TIME_BITS < IN_W) ? TIME_BITS : IN_W;
  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  fsm_state_t    state_r, state_nxt;
  cell_ctrl_t    ctrl;
  logic [CW-1:0] cnt_r, rem_r;
  logic [TIME_W-1:0] cur_r;
  logic [TOT_W-1:0]  tt_r, tw_r;

  logic              accept_in, set_end, pop, last_pop, div_start;
  logic [CW-1:0]     cnt_inc;

  logic [MAX_PROCS:0] c_val;
  logic [TW-1:0]      c_arr [MAX_PROCS+1];
  logic [TW-1:0]      c_bur [MAX_PROCS+1];
  logic [IW-1:0]      c_idx [MAX_PROCS+1];
  logic [MAX_PROCS-1:0] c_ins;
  logic [MAX_PROCS-1:0] l_ins, l_val;
  logic [TW-1:0]      l_arr [MAX_PROCS];
  logic [TW-1:0]      l_bur [MAX_PROCS];
  logic [IW-1:0]      l_idx [MAX_PROCS];

  logic [TIME_W-1:0] h_arr, h_bur, start_t, comp, tat, wt;
  logic [TOT_W-1:0]  tt_sum, tw_sum;

  logic              div_t_done, div_w_done;
  logic [DIVD_W-1:0] div_t_q, div_w_q;

  logic              out_valid_r;
  logic [PID_W-1:0]  out_pid_r;
  logic [IN_W-1:0]   out_arr_r, out_bur_r;
  logic [TIME_W-1:0] out_comp_r, out_tat_r, out_wt_r;
  logic [AVG_W-1:0]  out_att_r, out_awt_r;
  logic              out_done_r;

  assign accept_in = in_valid && in_ready;
  assign cnt_inc   = cnt_r + 1'b1;
  assign set_end   = in_last || (cnt_inc == CW'(MAX_PROCS));
  assign pop       = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);
  assign last_pop  = pop && (rem_r == CW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (accept_in && set_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (last_pop) state_nxt = ST_DIV;
      ST_DIV:   if (div_t_done) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_LOAD);
    ctrl.ins  = accept_in;
    ctrl.pop  = pop;
    div_start = last_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign c_val[MAX_PROCS] = 1'b0;
  assign c_arr[MAX_PROCS] = '0;
  assign c_bur[MAX_PROCS] = '0;
  assign c_idx[MAX_PROCS] = '0;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign l_ins[g] = 1'b0;
      assign l_val[g] = 1'b0;
      assign l_arr[g] = '0;
      assign l_bur[g] = '0;
      assign l_idx[g] = '0;
    end else begin : g_body
      assign l_ins[g] = c_ins[g-1];
      assign l_val[g] = c_val[g-1];
      assign l_arr[g] = c_arr[g-1];
      assign l_bur[g] = c_bur[g-1];
      assign l_idx[g] = c_idx[g-1];
    end

    fcfs_cell #(
      .TW(TW),
      .IW(IW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .new_arr (in_arrival[TW-1:0]),
      .new_bur (in_burst[TW-1:0]),
      .new_idx (cnt_r[IW-1:0]),
      .lft_ins (l_ins[g]),
      .lft_val (l_val[g]),
      .lft_arr (l_arr[g]),
      .lft_bur (l_bur[g]),
      .lft_idx (l_idx[g]),
      .rgt_val (c_val[g+1]),
      .rgt_arr (c_arr[g+1]),
      .rgt_bur (c_bur[g+1]),
      .rgt_idx (c_idx[g+1]),
      .val     (c_val[g]),
      .arr     (c_arr[g]),
      .bur     (c_bur[g]),
      .idx     (c_idx[g]),
      .ins     (c_ins[g])
    );
  end

  assign h_arr   = TIME_W'(c_arr[0]);
  assign h_bur   = TIME_W'(c_bur[0]);
  assign start_t = (cur_r < h_arr) ? h_arr : cur_r;
  assign comp    = start_t + h_bur;
  assign tat     = comp - h_arr;
  assign wt      = tat - h_bur;
  assign tt_sum  = tt_r + TOT_W'(tat);
  assign tw_sum  = tw_r + TOT_W'(wt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rem_r <= '0;
      cur_r <= '0;
      tt_r  <= '0;
      tw_r  <= '0;
    end else if (accept_in) begin
      cnt_r <= cnt_inc;
      if (set_end) begin
        rem_r <= cnt_inc;
      end
    end else if (pop) begin
      rem_r <= rem_r - 1'b1;
      cur_r <= comp;
      tt_r  <= tt_sum;
      tw_r  <= tw_sum;
    end else if (state_r == ST_DIV && div_t_done) begin
      cnt_r <= '0;
      cur_r <= '0;
      tt_r  <= '0;
      tw_r  <= '0;
    end
  end

  fcfs_div #(
    .DW(DIVD_W),
    .VW(CW)
  ) u_div_tat (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({tt_sum, FRAC_W'(0)}),
    .divisor  (cnt_r),
    .done     (div_t_done),
    .quotient (div_t_q)
  );

  fcfs_div #(
    .DW(DIVD_W),
    .VW(CW)
  ) u_div_wt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({tw_sum, FRAC_W'(0)}),
    .divisor  (cnt_r),
    .done     (div_w_done),
    .quotient (div_w_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && !last_pop) begin
      out_valid_r <= 1'b1;
    end else if (state_r == ST_DIV && div_t_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the final beat until both averages land
  always_ff @(posedge clk) begin
    if (pop) begin
      out_pid_r  <= PID_W'({1'b0, c_idx[0]} + 1'b1);
      out_arr_r  <= IN_W'(c_arr[0]);
      out_bur_r  <= IN_W'(c_bur[0]);
      out_comp_r <= comp;
      out_tat_r  <= tat;
      out_wt_r   <= wt;
      out_att_r  <= '0;
      out_awt_r  <= '0;
      out_done_r <= 1'b0;
    end else if (state_r == ST_DIV && div_t_done) begin
      out_att_r  <= div_t_q[AVG_W-1:0];
      out_awt_r  <= div_w_q[AVG_W-1:0];
      out_done_r <= 1'b1;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_proc_id           = out_pid_r;
  assign out_arrival_out       = out_arr_r;
  assign out_burst_out         = out_bur_r;
  assign out_completion        = out_comp_r;
  assign out_turnaround        = out_tat_r;
  assign out_waiting           = out_wt_r;
  assign out_avg_turnaround_q8 = out_att_r;
  assign out_avg_waiting_q8    = out_awt_r;
  assign out_done_res          = out_done_r;

  `FCFS_ASSERT(a_cells_packed, clk, rst_n, ((c_val[MAX_PROCS-1:0] & (c_val[MAX_PROCS-1:0] + 1'b1)) == '0), "occupied cells not contiguous from the head")
  `FCFS_IMPLY(a_head_sorted, clk, rst_n, c_val[1], (c_arr[0] <= c_arr[1]), "head cells out of arrival order")
  `FCFS_ASSERT(a_div_lockstep, clk, rst_n, (div_t_done == div_w_done), "average dividers out of step")
  `FCFS_IMPLY(a_drain_count, clk, rst_n, (state_r == ST_DRAIN), (rem_r != '0), "drain with nothing left to pop")
  `FCFS_IMPLY(a_final_held, clk, rst_n, (state_r == ST_DIV), (!out_valid_r), "result shown before averages finish")

endmodule
